@@ rtl/name_table_directory_assert.svh @@
// Assertion macros for the name table directory checker.
// Depends on nothing; included by the checker file only.
`ifndef NAME_TABLE_DIRECTORY_ASSERT_SVH
`define NAME_TABLE_DIRECTORY_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define NTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define NTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ntd_pkg.sv @@
// Shared types and constants for the name table directory.
// No dependencies; used by every other file of the block except the assertion macro header.
`default_nettype none

package ntd_pkg;

    localparam int WORD0_W     = 64;
    localparam int WORD1_W     = 64;
    localparam int WORD2_W     = 24;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 4;
    localparam int MAX_RESULTS = 16;
    localparam int DEF_ENTRIES = 16;

    // One stored name, three little-endian words
    typedef struct packed {
        logic [WORD2_W-1:0] w2;
        logic [WORD1_W-1:0] w1;
        logic [WORD0_W-1:0] w0;
    } t_name;

    typedef enum logic [MODE_W-1:0] {
        OP_CREATE = 3'd0,
        OP_DELETE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_LIST   = 3'd3,
        OP_RENAME = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // One result item as handed from the controller to the output stage
    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   position;
        t_name              entry;
        logic               last;
    } t_rsp;

endpackage

`default_nettype wire

@@ rtl/ntd_if.sv @@
// Request and response channel interfaces of the name table directory.
// Depends on ntd_pkg for field widths.
`default_nettype none

interface ntd_req_if;
    logic                              valid;
    logic                              ready;
    logic [ntd_pkg::MODE_W-1:0]        mode;
    logic [ntd_pkg::WORD0_W-1:0]       key_word0;
    logic [ntd_pkg::WORD1_W-1:0]       key_word1;
    logic [ntd_pkg::WORD2_W-1:0]       key_word2;
    logic [ntd_pkg::WORD0_W-1:0]       new_word0;
    logic [ntd_pkg::WORD1_W-1:0]       new_word1;
    logic [ntd_pkg::WORD2_W-1:0]       new_word2;

    modport source (
        output valid, mode, key_word0, key_word1, key_word2,
               new_word0, new_word1, new_word2,
        input  ready
    );
    modport sink (
        input  valid, mode, key_word0, key_word1, key_word2,
               new_word0, new_word1, new_word2,
        output ready
    );
endinterface

interface ntd_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ntd_pkg::STATUS_W-1:0]      status;
    logic [ntd_pkg::POS_W-1:0]         position;
    logic [ntd_pkg::WORD0_W-1:0]       entry_word0;
    logic [ntd_pkg::WORD1_W-1:0]       entry_word1;
    logic [ntd_pkg::WORD2_W-1:0]       entry_word2;
    logic                              last;

    modport source (
        output valid, status, position, entry_word0, entry_word1, entry_word2, last,
        input  ready
    );
    modport sink (
        input  valid, status, position, entry_word0, entry_word1, entry_word2, last,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/ntd_mem.sv @@
// Name storage: one write port, one read port with registered read data.
// Depends on ntd_pkg for the stored name type.
`default_nettype none

module ntd_mem #(
    parameter int DEPTH = ntd_pkg::DEF_ENTRIES,
    parameter int IDX_W = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_wr_en,
    input  wire logic [IDX_W-1:0]    i_wr_addr,
    input  wire ntd_pkg::t_name      i_wr_data,
    input  wire logic                i_rd_en,
    input  wire logic [IDX_W-1:0]    i_rd_addr,
    output      ntd_pkg::t_name      o_rd_data
);

    ntd_pkg::t_name r_mem [DEPTH];
    ntd_pkg::t_name r_rd_data;

    // Write a name
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read a name; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/ntd_ctrl.sv @@
// Operation sequencer: scan, shift, list and update of the name storage.
// Depends on ntd_pkg and ntd_req_if; drives ntd_mem and the output stage.
`default_nettype none

module ntd_ctrl #(
    parameter int ENTRIES = ntd_pkg::DEF_ENTRIES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    ntd_req_if.sink                  i_req,
    output      logic                o_emit,
    output      ntd_pkg::t_rsp       o_rsp_data,
    input  wire logic                i_out_free,
    output      logic                o_wr_en,
    output      logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_wr_addr,
    output      ntd_pkg::t_name      o_wr_data,
    output      logic                o_rd_en,
    output      logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_rd_addr,
    input  wire ntd_pkg::t_name      i_rd_data
);

    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LP_POS_W = ntd_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_LRD,
        S_LOUT,
        S_RESP
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_ptr, n_ptr;
    logic [CNT_W-1:0]         r_widx, n_widx;
    logic [CNT_W-1:0]         r_lim, n_lim;
    logic                     r_pend, n_pend;
    logic [ntd_pkg::MODE_W-1:0] r_mode, n_mode;
    ntd_pkg::t_name           r_key, n_key;
    ntd_pkg::t_name           r_new, n_new;
    ntd_pkg::t_status         r_status, n_status;

    ntd_pkg::t_name           req_key;
    ntd_pkg::t_name           req_new;
    logic [CNT_W-1:0]         ptr_m1;
    logic [CNT_W-1:0]         ptr_p1;
    logic                     hit;
    logic                     list_last;

    assign req_key   = {i_req.key_word2, i_req.key_word1, i_req.key_word0};
    assign req_new   = {i_req.new_word2, i_req.new_word1, i_req.new_word0};
    assign ptr_m1    = r_ptr - CNT_W'(1);
    assign ptr_p1    = r_ptr + CNT_W'(1);
    assign hit       = r_pend && (i_rd_data == r_key);
    assign list_last = (ptr_p1 == r_lim);

    assign i_req.ready = (r_state == S_IDLE);

    // Sequence one item through the storage
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_widx   = r_widx;
        n_lim    = r_lim;
        n_pend   = r_pend;
        n_mode   = r_mode;
        n_key    = r_key;
        n_new    = r_new;
        n_status = r_status;

        o_wr_en   = 1'b0;
        o_wr_addr = r_widx[IDX_W-1:0];
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr[IDX_W-1:0];

        o_emit              = 1'b0;
        o_rsp_data.status   = r_status;
        o_rsp_data.position = '0;
        o_rsp_data.entry    = '0;
        o_rsp_data.last     = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode = i_req.mode;
                    n_key  = req_key;
                    n_new  = req_new;
                    n_ptr  = '0;
                    n_pend = 1'b0;
                    case (i_req.mode)
                        ntd_pkg::OP_CREATE: begin
                            if (r_count == CNT_W'(ENTRIES)) begin
                                n_status = ntd_pkg::ST_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_count[IDX_W-1:0];
                                o_wr_data = req_key;
                                n_count   = r_count + CNT_W'(1);
                                n_status  = ntd_pkg::ST_OK;
                            end
                            n_state = S_RESP;
                        end
                        ntd_pkg::OP_LIST: begin
                            if (r_count == '0) begin
                                n_status = ntd_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                // Cap the listing at the result limit
                                if (32'(r_count) > ntd_pkg::MAX_RESULTS) begin
                                    n_lim = CNT_W'(ntd_pkg::MAX_RESULTS);
                                end else begin
                                    n_lim = r_count;
                                end
                                n_state = S_LRD;
                            end
                        end
                        ntd_pkg::OP_DELETE, ntd_pkg::OP_SEARCH, ntd_pkg::OP_RENAME: begin
                            if (r_count == '0) begin
                                n_status = ntd_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // Drop unknown modes without a result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Compare the entry read last cycle, issue the next read
                if (hit) begin
                    n_status = ntd_pkg::ST_OK;
                    case (r_mode)
                        ntd_pkg::OP_DELETE: begin
                            n_widx  = ptr_m1;
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end
                        ntd_pkg::OP_RENAME: begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = ptr_m1[IDX_W-1:0];
                            o_wr_data = r_new;
                            n_state   = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end else if (r_ptr < r_count) begin
                    o_rd_en = 1'b1;
                    n_ptr   = ptr_p1;
                    n_pend  = 1'b1;
                end else begin
                    n_status = ntd_pkg::ST_MISSING;
                    n_state  = S_RESP;
                end
            end

            S_SHIFT: begin
                // Move each later entry down by one place
                if (r_pend) begin
                    o_wr_en = 1'b1;
                    n_widx  = r_widx + CNT_W'(1);
                end
                if (r_ptr < r_count) begin
                    o_rd_en = 1'b1;
                    n_ptr   = ptr_p1;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count  = r_count - CNT_W'(1);
                        n_status = ntd_pkg::ST_OK;
                        n_state  = S_RESP;
                    end
                end
            end

            S_LRD: begin
                o_rd_en = 1'b1;
                n_state = S_LOUT;
            end

            S_LOUT: begin
                // Offer one listed entry; advance once the output takes it
                o_emit              = 1'b1;
                o_rsp_data.status   = ntd_pkg::ST_OK;
                o_rsp_data.position = LP_POS_W'(r_ptr);
                o_rsp_data.entry    = i_rd_data;
                o_rsp_data.last     = list_last;
                if (i_out_free) begin
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = ptr_p1;
                        n_state = S_LRD;
                    end
                end
            end

            S_RESP: begin
                o_emit = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state; control clears on reset, payload does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_ptr    <= n_ptr;
        r_widx   <= n_widx;
        r_lim    <= n_lim;
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_new    <= n_new;
        r_status <= n_status;
    end

endmodule

`default_nettype wire

@@ rtl/name_table_directory.sv @@
// Search and rename scan the entries with one memory read per entry; delete scans to the
// match, then does one read and one write per cycle to close the gap; list reads each entry
// in turn. One item is taken at a time; a full listing is the worst case, set by the single
// read port. Results sit in an output register.
// Reset clears the entry count and the control state; stored names are not cleared.
// Top level of the name table directory.
// Depends on ntd_pkg, ntd_if, ntd_mem and ntd_ctrl.
`default_nettype none

module name_table_directory #(
    parameter int ENTRIES = ntd_pkg::DEF_ENTRIES
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ntd_req_if.sink      i_req,
    ntd_rsp_if.source    o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic               emit;
    logic               out_free;
    ntd_pkg::t_rsp      rsp_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    ntd_pkg::t_name     wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    ntd_pkg::t_name     rd_data;

    logic               r_out_valid;
    ntd_pkg::t_rsp      r_out;

    ntd_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_emit     (emit),
        .o_rsp_data (rsp_data),
        .i_out_free (out_free),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    ntd_mem #(
        .DEPTH (ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || o_rsp.ready;

    // Load a result item, hold it until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
        if (emit && out_free) begin
            r_out <= rsp_data;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.position    = r_out.position;
    assign o_rsp.entry_word0 = r_out.entry.w0;
    assign o_rsp.entry_word1 = r_out.entry.w1;
    assign o_rsp.entry_word2 = r_out.entry.w2;
    assign o_rsp.last        = r_out.last;

endmodule

`default_nettype wire

@@ rtl/ntd_chk.sv @@
// Port-level checker for the name table directory, bound to the top level.
// Depends on ntd_pkg and name_table_directory_assert.svh.
`default_nettype none
`include "name_table_directory_assert.svh"

module ntd_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_rsp_valid,
    input wire logic                                i_rsp_ready,
    input wire logic [ntd_pkg::STATUS_W-1:0]        i_rsp_status,
    input wire logic [ntd_pkg::POS_W-1:0]           i_rsp_position,
    input wire logic [ntd_pkg::WORD0_W-1:0]         i_rsp_word0,
    input wire logic [ntd_pkg::WORD1_W-1:0]         i_rsp_word1,
    input wire logic [ntd_pkg::WORD2_W-1:0]         i_rsp_word2,
    input wire logic                                i_rsp_last
);

    // A stalled item holds its status, position and last flag
    `NTD_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_position) && $stable(i_rsp_last), "result changed while stalled")

    // Only a listing gives several items, all of them ok
    `NTD_ASSERT_IMP(a_multi_ok, i_clk, i_rst_n, i_rsp_valid && !i_rsp_last, i_rsp_status == ntd_pkg::ST_OK, "non-final result with error status")

    // Error results carry no position and no name
    `NTD_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status != ntd_pkg::ST_OK), (i_rsp_position == '0) && (i_rsp_word0 == '0) && (i_rsp_word1 == '0) && (i_rsp_word2 == '0), "error result with payload")

    // Listed positions advance by one
    `NTD_ASSERT_NXT(a_list_step, i_clk, i_rst_n, i_rsp_valid && i_rsp_ready && !i_rsp_last, !i_rsp_valid || (i_rsp_position == $past(i_rsp_position) + 4'd1), "list position skipped")

endmodule

bind name_table_directory ntd_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_position (o_rsp.position),
    .i_rsp_word0    (o_rsp.entry_word0),
    .i_rsp_word1    (o_rsp.entry_word1),
    .i_rsp_word2    (o_rsp.entry_word2),
    .i_rsp_last     (o_rsp.last)
);

`default_nettype wire

@@ tb/tb_name_table_directory.sv @@
// Self-checking testbench for the name table directory: create, delete, search, list, rename.
// Depends on ntd_pkg, the ntd_req_if / ntd_rsp_if channel interfaces and name_table_directory.
`default_nettype none

module tb_name_table_directory;

    localparam int ENTRIES      = ntd_pkg::DEF_ENTRIES;
    localparam int NAME_BYTES   = 19;
    localparam int NAME_BITS    = ntd_pkg::WORD0_W + ntd_pkg::WORD1_W + ntd_pkg::WORD2_W;
    localparam int RANDOM_ITEMS = 240;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
    localparam int MODE_UNUSED_LO = 5;
    localparam int MODE_UNUSED_HI = 7;

    typedef struct packed {
        logic [ntd_pkg::MODE_W-1:0] mode;
        ntd_pkg::t_name             key;
        ntd_pkg::t_name             nw;
    } t_dir_req;

    typedef struct packed {
        t_dir_req         rq;
        logic             fixed;
        ntd_pkg::t_status fixed_st;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    ntd_req_if req_if ();
    ntd_rsp_if rsp_if ();

    name_table_directory #(.ENTRIES(ENTRIES)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow directory and the results it predicts, oldest first
    ntd_pkg::t_name name_store [ENTRIES];
    int unsigned    name_count;
    ntd_pkg::t_rsp  dir_rsp_q [$];
    t_dir_row       dir_rows [$];

    int            fail_count;
    int            results_checked;
    int            full_seen;
    int            peak_count;
    int            op_count [8];
    logic          hold_req;
    ntd_pkg::t_rsp exp_rsp;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #4000000;
        $error("timeout: %0d results still outstanding", dir_rsp_q.size());
        $display("name_table_directory test failed");
        $finish;
    end

    // Apply one operation to the shadow directory and queue the results it causes
    function automatic void apply_dir_op(t_dir_req rq);
        int            hit;
        int            n;
        ntd_pkg::t_rsp r;
        hit = -1;
        r = '{status: ntd_pkg::ST_OK, position: '0, entry: '0, last: 1'b1};
        if (rq.mode > ntd_pkg::OP_RENAME) return;
        if (rq.mode == ntd_pkg::OP_CREATE) begin
            if (name_count >= ENTRIES) begin
                r.status = ntd_pkg::ST_FULL;
            end else begin
                name_store[name_count] = rq.key;
                name_count++;
                if (name_count > peak_count) peak_count = name_count;
            end
            dir_rsp_q.push_back(r);
            return;
        end
        if (name_count == 0) begin
            r.status = ntd_pkg::ST_EMPTY;
            dir_rsp_q.push_back(r);
            return;
        end
        if (rq.mode == ntd_pkg::OP_LIST) begin
            n = (name_count > ntd_pkg::MAX_RESULTS) ? ntd_pkg::MAX_RESULTS : name_count;
            for (int i = 0; i < n; i++) begin
                r.position = ntd_pkg::POS_W'(i);
                r.entry    = name_store[i];
                r.last     = (i == n - 1);
                dir_rsp_q.push_back(r);
            end
            return;
        end
        // Find the first exact match over all three words
        for (int i = 0; i < name_count; i++) begin
            if (hit < 0 && name_store[i] == rq.key) hit = i;
        end
        if (hit < 0) begin
            r.status = ntd_pkg::ST_MISSING;
        end else if (rq.mode == ntd_pkg::OP_DELETE) begin
            for (int i = hit; i + 1 < name_count; i++) name_store[i] = name_store[i + 1];
            name_count--;
        end else if (rq.mode == ntd_pkg::OP_RENAME) begin
            name_store[hit] = rq.nw;
        end
        dir_rsp_q.push_back(r);
    endfunction

    // Pack an ASCII string into a zero-padded little-endian name
    function automatic ntd_pkg::t_name pack_text(string s);
        ntd_pkg::t_name nm;
        nm = '0;
        for (int i = 0; i < s.len() && i < NAME_BYTES; i++) nm[8*i +: 8] = s[i];
        return nm;
    endfunction

    // Random name: mostly text of random length, sometimes raw bits
    function automatic ntd_pkg::t_name rand_name();
        ntd_pkg::t_name nm;
        int             len;
        nm = '0;
        if ($urandom_range(0, 9) < 3) begin
            nm.w0 = {$urandom, $urandom};
            nm.w1 = {$urandom, $urandom};
            nm.w2 = ntd_pkg::WORD2_W'($urandom);
        end else begin
            len = $urandom_range(0, NAME_BYTES);
            for (int i = 0; i < len; i++) nm[8*i +: 8] = 8'($urandom_range(1, 255));
        end
        return nm;
    endfunction

    function automatic ntd_pkg::t_name pick_stored();
        return name_store[$urandom_range(0, name_count - 1)];
    endfunction

    // Key: mostly a stored name, sometimes a near miss, else random
    function automatic ntd_pkg::t_name pick_key();
        ntd_pkg::t_name nm;
        int             roll;
        roll = $urandom_range(0, 99);
        if (name_count > 0 && roll < 80) begin
            nm = pick_stored();
        end else if (name_count > 0 && roll < 88) begin
            nm = pick_stored();
            nm[$urandom_range(0, NAME_BITS - 1)] ^= 1'b1;
        end else begin
            nm = rand_name();
        end
        return nm;
    endfunction

    // Build one random request; fill phases lean on create
    function automatic t_dir_req rand_dir_req(bit fill);
        t_dir_req rq;
        int       roll;
        rq.key = pick_key();
        rq.nw  = rand_name();
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            rq.mode = ntd_pkg::MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end else if (roll < (fill ? 61 : 21)) begin
            rq.mode = ntd_pkg::OP_CREATE;
            rq.key  = (name_count > 0 && $urandom_range(0, 4) == 0) ? pick_stored()
                                                                     : rand_name();
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 30)      rq.mode = ntd_pkg::OP_DELETE;
            else if (roll < 60) rq.mode = ntd_pkg::OP_SEARCH;
            else if (roll < 72) rq.mode = ntd_pkg::OP_LIST;
            else begin
                rq.mode = ntd_pkg::OP_RENAME;
                if (name_count > 0 && $urandom_range(0, 9) < 3) rq.nw = pick_stored();
            end
        end
        return rq;
    endfunction

    function automatic void add_row(logic [ntd_pkg::MODE_W-1:0] mode, ntd_pkg::t_name key,
                                    ntd_pkg::t_name nw, logic fixed, ntd_pkg::t_status st);
        t_dir_row row;
        row.rq.mode = mode;
        row.rq.key  = key;
        row.rq.nw   = nw;
        row.fixed    = fixed;
        row.fixed_st = st;
        dir_rows.push_back(row);
    endfunction

    // Directed rows: typed status where it is obvious, predictor otherwise
    function automatic void build_directed_table();
        ntd_pkg::t_name zero_nm;
        ntd_pkg::t_name ones_nm;
        ntd_pkg::t_name near_nm;
        ntd_pkg::t_name alpha;
        ntd_pkg::t_name gamma;
        ntd_pkg::t_name longest;
        zero_nm = '0;
        ones_nm = '1;
        near_nm = ones_nm;
        near_nm.w2[0] = 1'b0;
        alpha   = pack_text("alpha");
        gamma   = pack_text("gamma");
        longest = pack_text("abcdefghijklmnopqrs");
        add_row(ntd_pkg::OP_LIST,   zero_nm, zero_nm, 1'b1, ntd_pkg::ST_EMPTY);
        add_row(ntd_pkg::OP_SEARCH, alpha,   zero_nm, 1'b1, ntd_pkg::ST_EMPTY);
        add_row(ntd_pkg::OP_DELETE, alpha,   zero_nm, 1'b1, ntd_pkg::ST_EMPTY);
        add_row(ntd_pkg::OP_RENAME, alpha,   ones_nm, 1'b1, ntd_pkg::ST_EMPTY);
        add_row(ntd_pkg::MODE_W'(MODE_UNUSED_LO), ones_nm, ones_nm, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_CREATE, zero_nm, ones_nm, 1'b1, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_CREATE, ones_nm, zero_nm, 1'b1, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_CREATE, alpha,   zero_nm, 1'b1, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_CREATE, alpha,   ones_nm, 1'b1, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_SEARCH, ones_nm, zero_nm, 1'b1, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_SEARCH, gamma,   zero_nm, 1'b1, ntd_pkg::ST_MISSING);
        add_row(ntd_pkg::OP_DELETE, gamma,   zero_nm, 1'b1, ntd_pkg::ST_MISSING);
        add_row(ntd_pkg::OP_RENAME, gamma,   alpha,   1'b1, ntd_pkg::ST_MISSING);
        add_row(ntd_pkg::OP_SEARCH, near_nm, zero_nm, 1'b1, ntd_pkg::ST_MISSING);
        add_row(ntd_pkg::OP_LIST,   zero_nm, zero_nm, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_RENAME, alpha,   ones_nm, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_DELETE, ones_nm, zero_nm, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_LIST,   ones_nm, ones_nm, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::MODE_W'(MODE_UNUSED_HI), ones_nm, ones_nm, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_DELETE, zero_nm, zero_nm, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_CREATE, longest, zero_nm, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_LIST,   zero_nm, zero_nm, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::MODE_W'(MODE_UNUSED_LO + 1), alpha, gamma, 1'b0, ntd_pkg::ST_OK);
        add_row(ntd_pkg::OP_SEARCH, longest, zero_nm, 1'b0, ntd_pkg::ST_OK);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one item, hold it until accepted, then predict its results
    task automatic drive_dir_req(t_dir_req rq, logic fixed, ntd_pkg::t_status fixed_st);
        int q_len;
        req_if.valid     <= 1'b1;
        req_if.mode      <= rq.mode;
        req_if.key_word0 <= rq.key.w0;
        req_if.key_word1 <= rq.key.w1;
        req_if.key_word2 <= rq.key.w2;
        req_if.new_word0 <= rq.nw.w0;
        req_if.new_word1 <= rq.nw.w1;
        req_if.new_word2 <= rq.nw.w2;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        op_count[rq.mode]++;
        q_len = dir_rsp_q.size();
        apply_dir_op(rq);
        if (fixed) begin
            // Swap the predicted result for the typed-in one
            while (dir_rsp_q.size() > q_len) void'(dir_rsp_q.pop_back());
            dir_rsp_q.push_back('{status: fixed_st, position: '0, entry: '0, last: 1'b1});
        end
    endtask

    task automatic idle_req(int gap);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        while (dir_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // Response sink: random stalls, ready bursts and one long hold-off
    initial begin
        int stall_left;
        int burst_left;
        int roll;
        bit hold_done;
        rsp_if.ready = 1'b0;
        stall_left   = 0;
        burst_left   = 0;
        hold_done    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
                burst_left = 0;
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else if (burst_left > 0) begin
                rsp_if.ready <= 1'b1;
                burst_left--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    rsp_if.ready <= 1'b1;
                    burst_left = $urandom_range(30, 80);
                end else if (roll < 75) begin
                    rsp_if.ready <= 1'b1;
                end else if (roll < 95) begin
                    rsp_if.ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else begin
                    rsp_if.ready <= 1'b0;
                    stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (dir_rsp_q.size() == 0) begin
                $error("unexpected result: status %0d position %0d last %0b",
                       rsp_if.status, rsp_if.position, rsp_if.last);
                fail_count++;
            end else begin
                exp_rsp = dir_rsp_q.pop_front();
                results_checked++;
                if (exp_rsp.status == ntd_pkg::ST_FULL) full_seen++;
                if (rsp_if.status !== exp_rsp.status) begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.position !== exp_rsp.position) begin
                    $error("position: expected %0d, got %0d",
                           exp_rsp.position, rsp_if.position);
                    fail_count++;
                end
                if (rsp_if.entry_word0 !== exp_rsp.entry.w0) begin
                    $error("entry_word0: expected %h, got %h",
                           exp_rsp.entry.w0, rsp_if.entry_word0);
                    fail_count++;
                end
                if (rsp_if.entry_word1 !== exp_rsp.entry.w1) begin
                    $error("entry_word1: expected %h, got %h",
                           exp_rsp.entry.w1, rsp_if.entry_word1);
                    fail_count++;
                end
                if (rsp_if.entry_word2 !== exp_rsp.entry.w2) begin
                    $error("entry_word2: expected %h, got %h",
                           exp_rsp.entry.w2, rsp_if.entry_word2);
                    fail_count++;
                end
                if (rsp_if.last !== exp_rsp.last) begin
                    $error("last: expected %0b, got %0b", exp_rsp.last, rsp_if.last);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases
    initial begin
        t_dir_req rq;
        int       random_items;
        int       burst;
        bit       hold_sent;
        bit       pause_done;
        req_if.valid     = 1'b0;
        req_if.mode      = '0;
        req_if.key_word0 = '0;
        req_if.key_word1 = '0;
        req_if.key_word2 = '0;
        req_if.new_word0 = '0;
        req_if.new_word1 = '0;
        req_if.new_word2 = '0;
        i_rst_n          = 1'b0;
        hold_req         = 1'b0;
        name_count       = 0;
        fail_count       = 0;
        results_checked  = 0;
        full_seen        = 0;
        peak_count       = 0;
        random_items     = 0;
        burst            = 0;
        hold_sent        = 1'b0;
        pause_done       = 1'b0;
        foreach (op_count[k]) op_count[k] = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_directed_table();
        foreach (dir_rows[k]) begin
            drive_dir_req(dir_rows[k].rq, dir_rows[k].fixed, dir_rows[k].fixed_st);
            idle_req(pick_gap());
        end
        req_if.valid <= 1'b0;
        wait_for_results();

        // Alternate fill and drain phases of 40 items each
        while (random_items < RANDOM_ITEMS) begin
            if (random_items == 100 && !hold_sent) begin
                hold_sent = 1'b1;
                hold_req <= 1'b1;
                burst = 24;
            end
            if (random_items == 200 && !pause_done) begin
                pause_done = 1'b1;
                req_if.valid <= 1'b0;
                wait_for_results();
            end
            rq = rand_dir_req(((random_items / 40) % 2) == 0);
            drive_dir_req(rq, 1'b0, ntd_pkg::ST_OK);
            if (rq.mode <= ntd_pkg::OP_RENAME) random_items++;
            if (burst > 0) begin
                burst--;
            end else if ($urandom_range(0, 99) < 4) begin
                burst = 20;
            end else begin
                idle_req(pick_gap());
            end
        end
        req_if.valid <= 1'b0;

        // Drain, then watch for stray results
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d create, %0d delete, %0d search, %0d list, %0d rename, %0d unused",
                 op_count[ntd_pkg::OP_CREATE], op_count[ntd_pkg::OP_DELETE],
                 op_count[ntd_pkg::OP_SEARCH], op_count[ntd_pkg::OP_LIST],
                 op_count[ntd_pkg::OP_RENAME],
                 op_count[5] + op_count[6] + op_count[7]);
        $display("checked %0d results, %0d table-full, peak occupancy %0d of %0d",
                 results_checked, full_seen, peak_count, ENTRIES);
        if (fail_count == 0) begin
            $display("name_table_directory test passed");
        end else begin
            $display("name_table_directory test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
